// File: design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro expands to a labeled concurrent assertion, or to nothing under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: design/amax_pkg.sv
// Package for the argmax unit: sizes, register indexes and the float compare.
// No dependencies.
`timescale 1ns / 1ps
package amax_pkg;
   localparam int INNER_MAX = 4096;
   localparam int AXIS_MAX = 65536;
   localparam int INNER_W = $clog2(INNER_MAX);
   localparam int AXIS_W = $clog2(AXIS_MAX);
   localparam int ICNT_W = 13;
   localparam int ACNT_W = 17;
   localparam logic [31:0] NEG_FLT_MAX_BITS = 32'hFF7F_FFFF;

   typedef enum logic [1:0] {
      REG_INNER_COUNT = 2'd0,
      REG_AXIS_LENGTH = 2'd1,
      REG_TIE_TAKE_LAST = 2'd2
   } reg_index_type;

   // Control passed from the sequencer to the update stage.
   typedef struct packed {
      logic              valid;
      logic [INNER_W-1:0] inner;
      logic [AXIS_W-1:0]  axis;
      logic              first;
      logic              last;
      logic              end_slice;
      logic [31:0]       value;
   } step_type;

   function automatic logic is_nan(input logic [31:0] a);
      is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   // True when a > b (or a >= b with ge) as IEEE floats; NaN never compares true.
   function automatic logic fp_wins(input logic [31:0] a, input logic [31:0] b,
                                    input logic ge);
      logic both_zero, eq, gt;
      both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      eq = both_zero || (a == b);
      if (a[31] != b[31]) gt = !a[31];
      else if (!a[31]) gt = a[30:0] > b[30:0];
      else gt = a[30:0] < b[30:0];
      gt = gt && !both_zero;
      fp_wins = !is_nan(a) && !is_nan(b) && (gt || (ge && eq));
   endfunction
endpackage

// File: design/amax_seq.sv
// Position sequencer: walks inner and axis positions for each accepted item.
// Depends on amax_pkg.
`timescale 1ns / 1ps
module amax_seq import amax_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic                advance,
   input  logic [ICNT_W-1:0]   inner_count,
   input  logic [ACNT_W-1:0]   axis_length,
   output logic [INNER_W-1:0]  inner_pos,
   output logic [AXIS_W-1:0]   axis_pos,
   output logic                first,
   output logic                last,
   output logic                end_slice
);
   logic [INNER_W-1:0] inner_ff, inner_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic [INNER_W-1:0] inner_last;
   logic [AXIS_W-1:0] axis_last;

   // Clamped terminal counts.
   always_comb begin
      if (inner_count == '0) inner_last = '0;
      else if (inner_count > ICNT_W'(INNER_MAX)) inner_last = INNER_W'(INNER_MAX - 1);
      else inner_last = INNER_W'(inner_count - 1'b1);
      if (axis_length == '0) axis_last = '0;
      else if (axis_length > ACNT_W'(AXIS_MAX)) axis_last = AXIS_W'(AXIS_MAX - 1);
      else axis_last = AXIS_W'(axis_length - 1'b1);
   end

   assign inner_pos = inner_ff;
   assign axis_pos = axis_ff;
   assign first = (axis_ff == '0);
   assign last = (axis_ff == axis_last);
   assign end_slice = (inner_ff == inner_last);

   // Next position.
   always_comb begin
      inner_in = inner_ff;
      axis_in = axis_ff;
      if (restart) begin
         inner_in = '0;
         axis_in = '0;
      end else if (advance) begin
         if (inner_ff == inner_last) begin
            inner_in = '0;
            axis_in = (axis_ff == axis_last) ? '0 : axis_ff + 1'b1;
         end else begin
            inner_in = inner_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= '0;
         axis_ff <= '0;
      end else begin
         inner_ff <= inner_in;
         axis_ff <= axis_in;
      end
   end
endmodule

// File: design/amax_store.sv
// Running-maximum memory with read-modify-write and write-back forwarding.
// Depends on amax_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module amax_store import amax_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  step_type           step,
   input  logic               tie_last,
   output logic               res_valid,
   output logic [AXIS_W-1:0]  res_index,
   output logic               res_end
);
   logic [31:0] val_mem [INNER_MAX];
   logic [AXIS_W-1:0] idx_mem [INNER_MAX];
   logic [31:0] rd_val_ff;
   logic [AXIS_W-1:0] rd_idx_ff;
   step_type s1_ff;
   logic wr_en;
   logic [INNER_W-1:0] wr_addr_ff;
   logic [31:0] wr_val_ff;
   logic [AXIS_W-1:0] wr_idx_ff;
   logic wr_en_ff;
   logic [31:0] old_val, new_val;
   logic [AXIS_W-1:0] old_idx, new_idx;
   logic fwd;

   // Read stage: memory read issued with the item.
   always_ff @(posedge clock) begin
      rd_val_ff <= val_mem[step.inner];
      rd_idx_ff <= idx_mem[step.inner];
   end

   always_ff @(posedge clock) begin
      if (reset) s1_ff.valid <= 1'b0;
      else s1_ff.valid <= step.valid;
      s1_ff.inner <= step.inner;
      s1_ff.axis <= step.axis;
      s1_ff.first <= step.first;
      s1_ff.last <= step.last;
      s1_ff.end_slice <= step.end_slice;
      s1_ff.value <= step.value;
   end

   // Compare stage, with forwarding from the write of the previous cycle.
   assign fwd = wr_en_ff && (wr_addr_ff == s1_ff.inner);
   always_comb begin
      if (s1_ff.first) begin
         old_val = NEG_FLT_MAX_BITS;
         old_idx = '0;
      end else if (fwd) begin
         old_val = wr_val_ff;
         old_idx = wr_idx_ff;
      end else begin
         old_val = rd_val_ff;
         old_idx = rd_idx_ff;
      end
      if (fp_wins(s1_ff.value, old_val, tie_last)) begin
         new_val = s1_ff.value;
         new_idx = s1_ff.axis;
      end else begin
         new_val = old_val;
         new_idx = old_idx;
      end
   end
   assign wr_en = s1_ff.valid;

   // Write back.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         val_mem[s1_ff.inner] <= new_val;
         idx_mem[s1_ff.inner] <= new_idx;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) wr_en_ff <= 1'b0;
      else wr_en_ff <= wr_en;
      wr_addr_ff <= s1_ff.inner;
      wr_val_ff <= new_val;
      wr_idx_ff <= new_idx;
   end

   assign res_valid = s1_ff.valid && s1_ff.last;
   assign res_index = new_idx;
   assign res_end = s1_ff.end_slice;

   `ASSERT_IMPL(a_first_fresh, clock, reset,
      (s1_ff.valid && s1_ff.first && !fp_wins(s1_ff.value, NEG_FLT_MAX_BITS, tie_last))
      |-> (new_idx == '0), "fresh axis start must give index 0")
   `ASSERT_IMPL(a_wb_follows, clock, reset, wr_en |=> wr_en_ff,
      "write back register must follow a write")
   `ASSERT_IMPL(a_idx_bound, clock, reset, (s1_ff.valid && !fwd && !s1_ff.first &&
      new_idx == s1_ff.axis) |-> (new_val == s1_ff.value), "winner value mismatch")
endmodule

// File: design/argmax_along_axis_unit.sv
// Top level of the argmax unit: handshakes, configuration, output skid stage.
// Depends on amax_pkg, amax_seq, amax_store and assert_macros.svh.
//
// Usage: elements stream in on req_ (valid/stall) in tensor order, slice,
// axis position, inner position. For each inner position the unit keeps a
// running maximum in a 4096-entry memory and, on the last axis position,
// returns the winning axis index on rsp_ with rsp_end_of_slice on the last
// inner position of a slice. Items whose maximum never beats -FLT_MAX give 0.
// Throughput is one item per cycle while req_stall is low: a read, one compare
// and a write-back per element, with the previous write forwarded when the same entry recurs.
// rsp_valid rises once the last-axis item has passed the store's compare-stage
// register and its result has been written into the output queue.
// A four-entry output queue lets the input keep flowing while the receiver
// holds rsp_stall; req_stall rises only when that queue could overflow.
// Reset clears positions, queue and registers (inner_count 1, axis_length 1,
// first index wins). The memory needs no clearing: every entry is written
// at axis position 0 before it is read. Any csr_ write restarts a slice.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module argmax_along_axis_unit import amax_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [31:0]  req_value_bits,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [15:0]  rsp_best_axis_index,
   output logic         rsp_end_of_slice,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   logic [ICNT_W-1:0] inner_count_ff;
   logic [ACNT_W-1:0] axis_length_ff;
   logic tie_ff;
   logic csr_we, accept;
   step_type step;
   logic res_valid, res_end;
   logic [AXIS_W-1:0] res_index;
   logic [INNER_W-1:0] inner_pos;
   logic [AXIS_W-1:0] axis_pos;
   logic first, last, end_slice;
   logic [1:0] s1_ff;
   logic [AXIS_W:0] q_ff [4];
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] rp_ff, wp_ff;
   logic pop;

   // Configuration registers.
   assign csr_ready = 1'b1;
   assign csr_we = csr_valid && csr_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_count_ff <= ICNT_W'(1);
         axis_length_ff <= ACNT_W'(1);
         tie_ff <= 1'b0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_INNER_COUNT: inner_count_ff <= csr_data[ICNT_W-1:0];
            REG_AXIS_LENGTH: axis_length_ff <= csr_data[ACNT_W-1:0];
            REG_TIE_TAKE_LAST: tie_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Queue holds results plus those still in flight; stall keeps room for them.
   assign req_stall = ({1'b0, cnt_ff} + {3'b0, s1_ff[0]} + {3'b0, s1_ff[1]}) >= 4'd4;
   assign accept = req_valid && !req_stall;

   amax_seq u_seq (
      .clock(clock), .reset(reset), .restart(csr_we), .advance(accept),
      .inner_count(inner_count_ff), .axis_length(axis_length_ff),
      .inner_pos(inner_pos), .axis_pos(axis_pos), .first(first), .last(last),
      .end_slice(end_slice)
   );

   always_comb begin
      step.valid = accept;
      step.inner = inner_pos;
      step.axis = axis_pos;
      step.first = first;
      step.last = last;
      step.end_slice = end_slice;
      step.value = req_value_bits;
   end

   amax_store u_store (
      .clock(clock), .reset(reset), .step(step), .tie_last(tie_ff),
      .res_valid(res_valid), .res_index(res_index), .res_end(res_end)
   );

   // Results in flight: bit 0 in the compare stage, bit 1 unused spare slot.
   always_ff @(posedge clock) begin
      if (reset) s1_ff <= '0;
      else s1_ff <= {1'b0, accept && last};
   end

   // Output queue.
   assign pop = rsp_valid && !rsp_stall;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_best_axis_index = q_ff[rp_ff][AXIS_W-1:0];
   assign rsp_end_of_slice = q_ff[rp_ff][AXIS_W];
   assign cnt_in = cnt_ff + {2'b0, res_valid} - {2'b0, pop};
   always_ff @(posedge clock) begin
      if (res_valid) q_ff[wp_ff] <= {res_end, res_index};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff <= '0;
         wp_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (pop) rp_ff <= rp_ff + 1'b1;
         if (res_valid) wp_ff <= wp_ff + 1'b1;
      end
   end

   `ASSERT_IMPL(a_no_overflow, clock, reset, !(cnt_ff == 3'd4 && res_valid && !pop),
      "output queue overflow")
   `ASSERT_IMPL(a_cnt_bound, clock, reset, cnt_ff <= 3'd4, "queue count out of range")
   `ASSERT_IMPL(a_flight, clock, reset, (accept && last) |=> res_valid,
      "result must follow a last-axis item")
endmodule

// File: tb/argmax_index_checker.sv
// Checker for the argmax unit: watches the csr_, req_ and rsp_ channels, keeps its own
// running maxima and compares every returned axis index with the predicted one.
// Depends on amax_pkg for the register indexes and sizes.
`timescale 1ns / 1ps
module argmax_index_checker import amax_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_value_bits,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_best_axis_index,
   input  logic        rsp_end_of_slice,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          winners_pending,
   output int          winners_seen
);
   typedef struct packed {
      logic [15:0] axis_index;
      logic        slice_end;
   } winner_type;

   winner_type  pending_winners[$];
   logic [31:0] held_max[INNER_MAX];
   logic [15:0] held_pos[INNER_MAX];
   int          inner_at;
   int          axis_at;
   logic [ICNT_W-1:0] inner_cfg;
   logic [ACNT_W-1:0] axis_cfg;
   logic        take_last_cfg;

   // Maps a float pattern to an unsigned key whose order is the float order.
   function automatic logic [31:0] order_key(input logic [31:0] b);
      if (b[30:0] == 31'd0) return 32'h8000_0000;
      if (b[31]) return ~b;
      return b | 32'h8000_0000;
   endfunction

   function automatic logic not_a_number(input logic [31:0] b);
      return (&b[30:23]) && (|b[22:0]);
   endfunction

   function automatic logic beats(input logic [31:0] a, input logic [31:0] held,
                                  input logic ge);
      if (not_a_number(a) || not_a_number(held)) return 1'b0;
      return (order_key(a) > order_key(held)) || (ge && order_key(a) == order_key(held));
   endfunction

   assign winners_pending = pending_winners.size();

   // Updates the running maximum for one element; returns 1 when it ends an axis.
   function automatic logic predict_winner(input logic [31:0] v, output winner_type w);
      int n_inner, n_axis, k, j;
      logic done;
      n_inner = (inner_cfg == 0) ? 1 : (inner_cfg > INNER_MAX) ? INNER_MAX : int'(inner_cfg);
      n_axis = (axis_cfg == 0) ? 1 : (axis_cfg > AXIS_MAX) ? AXIS_MAX : int'(axis_cfg);
      k = (inner_at >= n_inner) ? 0 : inner_at;
      j = (axis_at >= n_axis) ? 0 : axis_at;
      if (j == 0) begin
         held_max[k] = NEG_FLT_MAX_BITS;
         held_pos[k] = '0;
      end
      if (beats(v, held_max[k], take_last_cfg)) begin
         held_max[k] = v;
         held_pos[k] = 16'(j);
      end
      done = (j == n_axis - 1);
      w.axis_index = held_pos[k];
      w.slice_end = (k == n_inner - 1);
      k++;
      if (k >= n_inner) begin
         k = 0;
         j++;
         if (j >= n_axis) j = 0;
      end
      inner_at = k;
      axis_at = j;
      return done;
   endfunction

   // All channels are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      winner_type w, got;
      if (reset) begin
         pending_winners.delete();
         inner_at = 0;
         axis_at = 0;
         inner_cfg = 1;
         axis_cfg = 1;
         take_last_cfg = 1'b0;
         fail_count = 0;
         winners_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            winners_seen++;
            got.axis_index = rsp_best_axis_index;
            got.slice_end = rsp_end_of_slice;
            if (pending_winners.size() == 0) begin
               fail_count++;
               $error("unexpected result: best_axis_index %0d end_of_slice %0b",
                      got.axis_index, got.slice_end);
            end else begin
               w = pending_winners.pop_front();
               if (got.axis_index !== w.axis_index) begin
                  fail_count++;
                  $error("best_axis_index: expected %0d, actual %0d",
                         w.axis_index, got.axis_index);
               end
               if (got.slice_end !== w.slice_end) begin
                  fail_count++;
                  $error("end_of_slice: expected %0b, actual %0b", w.slice_end, got.slice_end);
               end
            end
         end
         // Any register write restarts the stream at the start of a slice.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INNER_COUNT: inner_cfg = csr_data[ICNT_W-1:0];
               REG_AXIS_LENGTH: axis_cfg = csr_data[ACNT_W-1:0];
               REG_TIE_TAKE_LAST: take_last_cfg = csr_data[0];
               default: ;
            endcase
            inner_at = 0;
            axis_at = 0;
         end
         if (req_valid && !req_stall) begin
            if (predict_winner(req_value_bits, w)) pending_winners.push_back(w);
         end
      end
   end
endmodule

// File: tb/tb.sv
// Testbench top for argmax_along_axis_unit: clock, reset, register writes and element
// stimulus with random idling; checking is done by argmax_index_checker.
// Depends on amax_pkg, the design files and tb/argmax_index_checker.sv.
`timescale 1ns / 1ps
module tb import amax_pkg::*;;
   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam logic [31:0] POS_INF = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF = 32'hFF80_0000;
   localparam logic [31:0] POS_ZERO = 32'h0000_0000;
   localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
   localparam logic [31:0] QUIET_NAN = 32'h7FC0_0000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_value_bits;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_best_axis_index;
   logic        rsp_end_of_slice;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;
   int          fail_count;
   int          winners_pending;
   int          winners_seen;
   int          items_sent;
   int          settings_used;
   logic        no_idle;
   logic        hold_request;

   argmax_along_axis_unit u_top (.*);

   argmax_index_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, or a long counted hold-off when asked.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = 300;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 7);
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits for every expected result, then for the pipeline to drain.
   task automatic wait_drained();
      while (winners_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] inner, input logic [31:0] axis,
                            input logic take_last);
      wait_drained();
      write_reg(REG_INNER_COUNT, inner);
      write_reg(REG_AXIS_LENGTH, axis);
      write_reg(REG_TIE_TAKE_LAST, {31'd0, take_last});
      settings_used++;
   endtask

   // Offers one item, starting and ending at a falling edge.
   task automatic send_item(input logic [31:0] v);
      while (!no_idle && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         req_value_bits <= $urandom;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value_bits <= v;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         4: case (r[2:0])
               0: return 32'h3F80_0000;
               1: return 32'hBF80_0000;
               2: return POS_ZERO;
               3: return NEG_ZERO;
               4: return POS_INF;
               5: return NEG_INF;
               6: return NEG_FLT_MAX_BITS;
               default: return 32'h4000_0000;
            endcase
         5: return {r[31], 8'hFF, r[22:1], 1'b1};
         6: return {r[31], 8'hFF, 23'd0};
         7: return {r[31], 31'd0};
         8: return NEG_FLT_MAX_BITS;
         9: return {1'b0, 8'd127 + 8'(r[1:0]), 23'(r[4:3]) << 21};
         default: return r;
      endcase
   endfunction

   task automatic send_slices(input int inner, input int axis, input int slices,
                              input logic truncate);
      int total;
      total = inner * axis * slices;
      if (truncate) total = $urandom_range(total - 1, 1);
      for (int i = 0; i < total; i++) send_item(pick_value());
   endtask

   // Elements of the directed set: two inner positions over four axis positions.
   logic [31:0] directed_set[8] = '{NEG_INF, POS_ZERO, QUIET_NAN, NEG_ZERO,
                                    NEG_FLT_MAX_BITS, 32'h0000_0001, NEG_INF, POS_ZERO};

   initial begin
      int inner, axis;
      logic take_last;
      reset = 1'b1;
      no_idle = 1'b0;
      hold_request = 1'b0;
      req_valid = 1'b0;
      req_value_bits = '0;
      csr_valid = 1'b0;
      csr_index = REG_INNER_COUNT;
      csr_data = '0;
      items_sent = 0;
      settings_used = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: zeros of both signs, NaN, infinities, -FLT_MAX, ties in both modes.
      configure(2, 4, 1'b0);
      foreach (directed_set[i]) send_item(directed_set[i]);
      req_valid <= 1'b0;
      configure(2, 4, 1'b1);
      foreach (directed_set[i]) send_item(directed_set[i]);
      send_item(32'h7F7F_FFFF);
      send_item(32'hFFFF_FFFF);
      req_valid <= 1'b0;
      // Zero register values act as one; a spare index only restarts the slice.
      configure(0, 0, 1'b0);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      send_item(NEG_INF);
      send_item(POS_INF);
      send_item(QUIET_NAN);
      req_valid <= 1'b0;

      // Largest inner count, clamped from an oversized value, without idling.
      // No result may close a slice this early.
      no_idle = 1'b1;
      configure(32'h1FFF, 1, 1'b1);
      for (int i = 0; i < 120; i++) send_item(pick_value());
      req_valid <= 1'b0;
      no_idle = 1'b0;
      // Longest axis, clamped from an oversized value; the next write cuts it short.
      configure(1, 32'h1_FFFF, 1'b0);
      for (int i = 0; i < 40; i++) send_item(pick_value());
      req_valid <= 1'b0;

      // Receiver holds off while the sender keeps offering one result per item.
      configure(4, 1, 1'b0);
      hold_request = 1'b1;
      send_slices(4, 1, 10, 1'b0);
      req_valid <= 1'b0;

      // Random settings with whole slices, some cut short by a register write.
      while (items_sent < 860) begin
         inner = ($urandom_range(9) == 0) ? $urandom_range(40, 2) : $urandom_range(6, 1);
         axis = ($urandom_range(9) == 0) ? $urandom_range(30, 2) : $urandom_range(6, 1);
         take_last = $urandom_range(1);
         configure(inner, axis, take_last);
         send_slices(inner, axis, $urandom_range(3, 1), $urandom_range(99) < 15);
         req_valid <= 1'b0;
      end
      wait_drained();
      repeat (20) @(negedge clock);

      $display("tb: %0d items over %0d register settings, %0d results checked",
               items_sent, settings_used, winners_seen);
      $display("tb: covered ties in both modes, NaN, infinities, signed zeros and clamping");
      if (fail_count == 0 && winners_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule
